### rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// condition holds at every clock edge out of reset
`define MLBC_ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (expr)) \
    else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define MLBC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define MLBC_ASSERT_ALWAYS(lbl, clk_s, rstn_s, expr)
`define MLBC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

### rtl/mlbc_pkg.sv
// types and constants of the multi led blink controller
`timescale 1ns / 1ps

package mlbc_pkg;

  // number of driven leds, 1 to 8
  localparam int LED_COUNT = 3;
  localparam int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 8;
  localparam int STEP_W     = 8;
  localparam int TIME_W     = 16;

  localparam logic [STEP_W-1:0] TICK_STEP_RESET = 8'd10;

  // item kinds carried in tuser
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  typedef enum logic [1:0] {
    MODE_OFF     = 2'd0,
    MODE_ON      = 2'd1,
    MODE_COUNTED = 2'd2,
    MODE_FOREVER = 2'd3
  } mode_t;

  // one led's state word
  typedef struct packed {
    mode_t             mode;
    logic [TIME_W-1:0] on_time;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] remaining;
    logic [TIME_W-1:0] timer;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] addr;
  } mem_rd_t;

  // finished tick result from the sequencer
  typedef struct packed {
    logic                  valid;
    logic [OUT_DATA_W-1:0] levels;
  } res_t;

endpackage

### rtl/mlbc_mem.sv
// led state memory, one write and one registered read port
`timescale 1ns / 1ps

module mlbc_mem
  import mlbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  mem_wr_t wr,
  input  mem_rd_t rd,
  output entry_t  rdata
);

  entry_t               mem [LED_COUNT];
  logic [LED_COUNT-1:0] valid_r;
  entry_t               rdata_r;
  logic                 rvalid_r;

  // data array, no reset
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.re) begin
      rdata_r <= mem[rd.addr];
    end
  end

  // per-entry valid bits, an unwritten entry reads as all zero (led off)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (wr.we) begin
        valid_r[wr.addr] <= 1'b1;
      end
      if (rd.re) begin
        rvalid_r <= valid_r[rd.addr];
      end
    end
  end

  assign rdata = rvalid_r ? rdata_r : '0;

endmodule

### rtl/mlbc_core.sv
// sequencer: applies set words and walks the leds on each tick
`timescale 1ns / 1ps

module mlbc_core
  import mlbc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_kind,
  input  logic [IN_DATA_W-1:0] in_data,
  input  logic                 cfg_we,
  input  logic [STEP_W-1:0]    cfg_wdata,
  input  logic                 out_free,
  output res_t                 res,
  output mem_wr_t              mem_wr,
  output mem_rd_t              mem_rd,
  input  entry_t               mem_rdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [LED_COUNT-1:0] levels_r, levels_nxt;
  logic [STEP_W-1:0]    step_r;

  logic                 in_fire;
  logic                 last;
  logic                 lit;
  logic                 at_end;
  logic [TIME_W-1:0]    rem_dec;
  logic [TIME_W-1:0]    timer_base;
  entry_t               upd;

  // set word fields
  logic [2:0]           f_index;
  logic [1:0]           f_mode;
  logic [TIME_W-1:0]    f_on_time;
  logic [TIME_W-1:0]    f_period;
  logic [TIME_W-1:0]    f_count;

  assign f_index   = in_data[2:0];
  assign f_mode    = in_data[4:3];
  assign f_on_time = in_data[20:5];
  assign f_period  = in_data[36:21];
  assign f_count   = in_data[52:37];

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign last     = (idx_r == IDX_W'(LED_COUNT - 1));

  // tick step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= TICK_STEP_RESET;
    end else if (cfg_we) begin
      step_r <= cfg_wdata;
    end
  end

  // per-led update on the entry just read
  always_comb begin
    upd        = mem_rdata;
    lit        = 1'b0;
    at_end     = (mem_rdata.timer >= mem_rdata.period);
    rem_dec    = (mem_rdata.remaining != '0) ? mem_rdata.remaining - 1'b1 : '0;
    timer_base = mem_rdata.timer;
    case (mem_rdata.mode)
      MODE_ON: begin
        lit = 1'b1;
      end
      MODE_COUNTED: begin
        lit = (mem_rdata.timer < mem_rdata.on_time);
        if (at_end) begin
          timer_base    = '0;
          upd.remaining = rem_dec;
          if (rem_dec == '0) begin
            upd.mode = MODE_OFF;
          end
        end
      end
      MODE_FOREVER: begin
        lit = (mem_rdata.timer <= mem_rdata.on_time);
        if (at_end) begin
          timer_base = '0;
        end
      end
      default: begin
        lit = 1'b0;
      end
    endcase
    upd.timer = TIME_W'(timer_base + {{(TIME_W - STEP_W){1'b0}}, step_r});
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    levels_nxt  = levels_r;
    mem_wr      = '0;
    mem_rd      = '0;
    res.valid   = 1'b0;
    res.levels  = OUT_DATA_W'(levels_r);
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_kind == KIND_SET) begin
            mem_wr.we             = ({1'b0, f_index} < 4'(LED_COUNT));
            mem_wr.addr           = f_index[IDX_W-1:0];
            mem_wr.data.mode      = mode_t'(f_mode);
            mem_wr.data.on_time   = f_on_time;
            mem_wr.data.period    = f_period;
            mem_wr.data.remaining = f_count;
            mem_wr.data.timer     = '0;
          end else begin
            mem_rd.re   = 1'b1;
            mem_rd.addr = '0;
            idx_nxt     = '0;
            state_nxt   = S_RUN;
          end
        end
      end
      S_RUN: begin
        // write back led idx_r while reading the next one, never the same entry
        mem_wr.we   = 1'b1;
        mem_wr.addr = idx_r;
        mem_wr.data = upd;
        // bits shift in from the top so led k lands at bit k after the walk
        levels_nxt  = (levels_r >> 1) | (LED_COUNT'(lit) << (LED_COUNT - 1));
        if (last) begin
          res.levels = OUT_DATA_W'(levels_nxt);
          if (out_free) begin
            res.valid = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_HOLD;
          end
        end else begin
          idx_nxt     = IDX_W'(idx_r + 1'b1);
          mem_rd.re   = 1'b1;
          mem_rd.addr = idx_nxt;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    levels_r <= levels_nxt;
  end

endmodule

### rtl/multi_led_blink_controller.sv
// top level of the multi led blink controller
`timescale 1ns / 1ps

// Drives LED_COUNT leds from per-led state words held in one small synchronous
// memory. A set word (tuser 1) loads one led's mode, on-time, period and count;
// an index at or beyond LED_COUNT is dropped. A tick word (tuser 0) first reads
// led 0 from memory, then does one read-modify-write per led through the single
// read port. Each tick yields one output word, the lit mask, held in an output
// register; if that register is still full when the walk ends, the tick waits
// there until the word is taken. tick_step is written through cfg_we/cfg_wdata
// while the block is idle, a rule the user must keep that the block does not
// enforce, and resets to 10.

`include "assert_macros.svh"

module multi_led_blink_controller
  import mlbc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // led_index, mode, on_time, blink_period, flash_count
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // led_levels
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [STEP_W-1:0]     cfg_wdata
);

  mem_wr_t               mem_wr;
  mem_rd_t               mem_rd;
  entry_t                mem_rdata;
  res_t                  res;
  logic                  out_free;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  mlbc_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (mem_wr),
    .rd    (mem_rd),
    .rdata (mem_rdata)
  );

  mlbc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_data   (in_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_free  (out_free),
    .res       (res),
    .mem_wr    (mem_wr),
    .mem_rd    (mem_rd),
    .mem_rdata (mem_rdata)
  );

  // output register
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r <= res.levels;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `MLBC_ASSERT_ALWAYS(a_no_overwrite, clk, rst_n, !(res.valid && out_valid_r && !out_tready))
  `MLBC_ASSERT_NEXT(a_tick_busy, clk, rst_n, in_tvalid && in_tready && (in_tuser == KIND_TICK), !in_tready)
  `MLBC_ASSERT_NEXT(a_set_single, clk, rst_n, in_tvalid && in_tready && (in_tuser == KIND_SET), in_tready)
  `MLBC_ASSERT_ALWAYS(a_no_rw_clash, clk, rst_n, !(mem_wr.we && mem_rd.re && (mem_wr.addr == mem_rd.addr)))

endmodule
